### hdl/complex_polynomial_evaluator_unit_defines.svh
// Assertion macros shared by the polynomial evaluator modules.
`ifndef COMPLEX_POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH
`define COMPLEX_POLYNOMIAL_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CPE_ASSERT_IMPL(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("cpe assertion failed");

// Next-cycle implication, disabled during reset.
`define CPE_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("cpe assertion failed");

`endif

### hdl/cpe_pkg.sv
// Package with types, constants and saturation for the polynomial evaluator.
package cpe_pkg;

    localparam int MAX_DEGREE = 6;
    localparam int FRAC_BITS  = 24;
    localparam int WORD_WIDTH = 32;
    localparam int NUM_COEFFS = MAX_DEGREE + 1;
    localparam int COEFF_W    = 2 * WORD_WIDTH;
    localparam int CNT_W      = 3;
    localparam int IDX_W      = 3;
    localparam int PROD_W     = 2 * WORD_WIDTH;
    localparam int DIFF_W     = PROD_W + 1;
    localparam int ACC_W      = 48;
    localparam int LATENCY    = 2 * NUM_COEFFS + 1;

    localparam logic [IDX_W-1:0] CFG_COUNT      = 3'd0;
    localparam logic [IDX_W-1:0] CFG_COEFF_BASE = 3'd1;

    localparam logic signed [WORD_WIDTH-1:0] ONE_Q = WORD_WIDTH'(1) << FRAC_BITS;

    localparam logic signed [ACC_W-1:0] WORD_MAX =
        {{(ACC_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] WORD_MIN =
        {{(ACC_W-WORD_WIDTH+1){1'b1}}, {(WORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] point_real;
        logic signed [WORD_WIDTH-1:0] point_imag;
    } point_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] value_real;
        logic signed [WORD_WIDTH-1:0] value_imag;
        logic                         saturated;
    } result_t;

    typedef struct packed {
        logic use_term;
        logic use_next;
    } cell_ctl_t;

    typedef struct packed {
        logic signed [WORD_WIDTH-1:0] z_r;
        logic signed [WORD_WIDTH-1:0] z_i;
        logic signed [WORD_WIDTH-1:0] p_r;
        logic signed [WORD_WIDTH-1:0] p_i;
        logic signed [ACC_W-1:0]      sum_r;
        logic signed [ACC_W-1:0]      sum_i;
        logic                         clip;
    } cell_bus_t;

    typedef struct packed {
        logic                         clip;
        logic signed [WORD_WIDTH-1:0] val;
    } sat_t;

    function automatic sat_t sat_word(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > WORD_MAX)
        begin
            r.clip = 1'b1;
            r.val  = WORD_MAX[WORD_WIDTH-1:0];
        end
        else if (v < WORD_MIN)
        begin
            r.clip = 1'b1;
            r.val  = WORD_MIN[WORD_WIDTH-1:0];
        end
        else
        begin
            r.clip = 1'b0;
            r.val  = v[WORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

### hdl/cpe_cell.sv
// Evaluator chain cell: adds one coefficient term if enabled and forms the next power.
`include "complex_polynomial_evaluator_unit_defines.svh"

module cpe_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cpe_pkg::cell_ctl_t          ctl,
    input  logic [cpe_pkg::COEFF_W-1:0] coeff,
    input  logic                        up_valid,
    input  cpe_pkg::cell_bus_t          up,
    output logic                        dn_valid,
    output cpe_pkg::cell_bus_t          dn
);
    import cpe_pkg::*;

    logic signed [WORD_WIDTH-1:0] c_r;
    logic signed [WORD_WIDTH-1:0] c_i;
    logic signed [WORD_WIDTH-1:0] p_r;
    logic signed [WORD_WIDTH-1:0] p_i;
    logic signed [WORD_WIDTH-1:0] z_r;
    logic signed [WORD_WIDTH-1:0] z_i;

    logic                         s1_valid_reg;
    logic signed [PROD_W-1:0]     cr_pr_reg;
    logic signed [PROD_W-1:0]     ci_pi_reg;
    logic signed [PROD_W-1:0]     cr_pi_reg;
    logic signed [PROD_W-1:0]     ci_pr_reg;
    logic signed [PROD_W-1:0]     pr_zr_reg;
    logic signed [PROD_W-1:0]     pi_zi_reg;
    logic signed [PROD_W-1:0]     pr_zi_reg;
    logic signed [PROD_W-1:0]     pi_zr_reg;
    logic signed [WORD_WIDTH-1:0] s1_z_r_reg;
    logic signed [WORD_WIDTH-1:0] s1_z_i_reg;
    logic signed [ACC_W-1:0]      s1_sum_r_reg;
    logic signed [ACC_W-1:0]      s1_sum_i_reg;
    logic                         s1_clip_reg;

    logic signed [DIFF_W-1:0]     term_r_d;
    logic signed [DIFF_W-1:0]     term_i_d;
    logic signed [DIFF_W-1:0]     pow_r_d;
    logic signed [DIFF_W-1:0]     pow_i_d;
    logic signed [ACC_W-1:0]      term_r;
    logic signed [ACC_W-1:0]      term_i;
    sat_t                         pow_r_sat;
    sat_t                         pow_i_sat;

    logic                         dn_valid_reg;
    cell_bus_t                    dn_reg;
    cell_bus_t                    dn_next;

    assign c_r = coeff[WORD_WIDTH-1:0];
    assign c_i = coeff[COEFF_W-1:WORD_WIDTH];
    assign p_r = up.p_r;
    assign p_i = up.p_i;
    assign z_r = up.z_r;
    assign z_i = up.z_i;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            dn_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= up_valid;
            dn_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_pr_reg    <= PROD_W'(c_r) * PROD_W'(p_r);
        ci_pi_reg    <= PROD_W'(c_i) * PROD_W'(p_i);
        cr_pi_reg    <= PROD_W'(c_r) * PROD_W'(p_i);
        ci_pr_reg    <= PROD_W'(c_i) * PROD_W'(p_r);
        pr_zr_reg    <= PROD_W'(p_r) * PROD_W'(z_r);
        pi_zi_reg    <= PROD_W'(p_i) * PROD_W'(z_i);
        pr_zi_reg    <= PROD_W'(p_r) * PROD_W'(z_i);
        pi_zr_reg    <= PROD_W'(p_i) * PROD_W'(z_r);
        s1_z_r_reg   <= z_r;
        s1_z_i_reg   <= z_i;
        s1_sum_r_reg <= up.sum_r;
        s1_sum_i_reg <= up.sum_i;
        s1_clip_reg  <= up.clip;
    end

    always_comb
    begin
        term_r_d  = DIFF_W'(cr_pr_reg) - DIFF_W'(ci_pi_reg);
        term_i_d  = DIFF_W'(cr_pi_reg) + DIFF_W'(ci_pr_reg);
        pow_r_d   = DIFF_W'(pr_zr_reg) - DIFF_W'(pi_zi_reg);
        pow_i_d   = DIFF_W'(pr_zi_reg) + DIFF_W'(pi_zr_reg);
        term_r    = ACC_W'(term_r_d >>> FRAC_BITS);
        term_i    = ACC_W'(term_i_d >>> FRAC_BITS);
        pow_r_sat = sat_word(ACC_W'(pow_r_d >>> FRAC_BITS));
        pow_i_sat = sat_word(ACC_W'(pow_i_d >>> FRAC_BITS));

        dn_next.z_r   = s1_z_r_reg;
        dn_next.z_i   = s1_z_i_reg;
        dn_next.p_r   = pow_r_sat.val;
        dn_next.p_i   = pow_i_sat.val;
        dn_next.sum_r = ctl.use_term ? s1_sum_r_reg + term_r : s1_sum_r_reg;
        dn_next.sum_i = ctl.use_term ? s1_sum_i_reg + term_i : s1_sum_i_reg;
        dn_next.clip  = s1_clip_reg
                        | (ctl.use_next & (pow_r_sat.clip | pow_i_sat.clip));
    end

    always_ff @(posedge clk)
    begin
        dn_reg <= dn_next;
    end

    assign dn_valid = dn_valid_reg;
    assign dn       = dn_reg;

    `CPE_ASSERT_IMPL(a_next_implies_term, clk, rst_n, ctl.use_next, ctl.use_term)
    `CPE_ASSERT_NEXT(a_skip_keeps_sum, clk, rst_n, s1_valid_reg && !ctl.use_term, dn.sum_r == $past(s1_sum_r_reg) && dn.sum_i == $past(s1_sum_i_reg))
    `CPE_ASSERT_NEXT(a_unused_power_no_clip, clk, rst_n, s1_valid_reg && !ctl.use_next, dn.clip == $past(s1_clip_reg))

endmodule

### hdl/complex_polynomial_evaluator_unit.sv
// Top level of the complex polynomial evaluator: configuration, cell chain and output stage.
//
// Usage: drive a point on point and raise start; a point is taken at every rising edge
// where start is high and busy is low. busy stays low, so one point may enter every cycle.
// Each point passes a chain of seven cells, one per coefficient, each cell being a multiply
// stage and a combine stage, then one saturation stage.
// The result word appears on result with done high for exactly one cycle, after the
// saturation stage, in the order the points entered. The receiver cannot stall, so nothing
// is held back and no word is dropped.
// Throughput is one word per cycle, since every stage of the chain advances in every cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index at a rising edge. Index 0 holds
// the coefficient count, indices 1 to 7 hold coefficients 0 to 6, imaginary part in the upper
// half. The user must make writes only while no point is in flight; the block does not enforce it.
// Reset (rst_n low, async) clears config and valid registers and drops all points in flight.
`include "complex_polynomial_evaluator_unit_defines.svh"

module complex_polynomial_evaluator_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cpe_pkg::point_t             point,
    input  logic                        cfg_we,
    input  logic [cpe_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cpe_pkg::COEFF_W-1:0] cfg_data,
    output logic                        done,
    output cpe_pkg::result_t            result
);
    import cpe_pkg::*;

    logic [CNT_W-1:0]   coeff_count_reg;
    logic [COEFF_W-1:0] coeff_reg [NUM_COEFFS];

    logic               chain_valid [NUM_COEFFS+1];
    cell_bus_t          chain_bus   [NUM_COEFFS+1];
    cell_ctl_t          cell_ctl    [NUM_COEFFS];

    sat_t               fin_r;
    sat_t               fin_i;
    logic               done_reg;
    result_t            result_reg;
    result_t            result_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_count_reg <= '0;
            for (int k = 0; k < NUM_COEFFS; k++)
            begin
                coeff_reg[k] <= '0;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_COUNT)
            begin
                coeff_count_reg <= cfg_data[CNT_W-1:0];
            end
            else
            begin
                coeff_reg[IDX_W'(cfg_index - CFG_COEFF_BASE)] <= cfg_data;
            end
        end
    end

    assign busy = 1'b0;

    assign chain_valid[0]     = start;
    assign chain_bus[0].z_r   = point.point_real;
    assign chain_bus[0].z_i   = point.point_imag;
    assign chain_bus[0].p_r   = ONE_Q;
    assign chain_bus[0].p_i   = '0;
    assign chain_bus[0].sum_r = '0;
    assign chain_bus[0].sum_i = '0;
    assign chain_bus[0].clip  = 1'b0;

    for (genvar k = 0; k < NUM_COEFFS; k++)
    begin : g_cell
        assign cell_ctl[k].use_term = coeff_count_reg > CNT_W'(k);
        assign cell_ctl[k].use_next = coeff_count_reg > CNT_W'(k + 1);

        cpe_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctl      (cell_ctl[k]),
            .coeff    (coeff_reg[k]),
            .up_valid (chain_valid[k]),
            .up       (chain_bus[k]),
            .dn_valid (chain_valid[k+1]),
            .dn       (chain_bus[k+1])
        );
    end

    always_comb
    begin
        fin_r = sat_word(chain_bus[NUM_COEFFS].sum_r);
        fin_i = sat_word(chain_bus[NUM_COEFFS].sum_i);
        result_next.value_real = fin_r.val;
        result_next.value_imag = fin_i.val;
        result_next.saturated  = chain_bus[NUM_COEFFS].clip | fin_r.clip | fin_i.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain_valid[NUM_COEFFS];
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `CPE_ASSERT_IMPL(a_start_gives_done, clk, rst_n, start, ##LATENCY done)
    `CPE_ASSERT_IMPL(a_done_from_start, clk, rst_n, done, $past(start, LATENCY))
    `CPE_ASSERT_IMPL(a_zero_count_zero, clk, rst_n, done && coeff_count_reg == '0, result.value_real == '0 && result.value_imag == '0 && !result.saturated)

endmodule
